// ===== src/vppc_pkg.sv =====
// Shared widths, codes, reset values and control types for the viewport pan controller.
package vppc_pkg;

  localparam int PIXEL_BITS    = 12;
  localparam int FRAC_BITS     = 8;
  localparam int TIME_BITS     = 24;
  localparam int POS_BITS      = PIXEL_BITS + FRAC_BITS;
  localparam int SPOS_BITS     = POS_BITS + 1;
  localparam int DIM_BITS      = PIXEL_BITS + 1;
  localparam int OFS_BITS      = PIXEL_BITS;
  localparam int HALF_BITS     = DIM_BITS + 1;
  localparam int ELAP_BITS     = TIME_BITS + 1;
  localparam int PROD_BITS     = POS_BITS + TIME_BITS;
  localparam int CALC_BITS     = POS_BITS + 4;
  localparam int OPC_BITS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = DIM_BITS;
  localparam int DIV_CNT_BITS  = $clog2(POS_BITS + 1);

  localparam logic signed [CALC_BITS-1:0] POS_MAX_C = CALC_BITS'((64'd1 << POS_BITS) - 64'd1);

  localparam logic [DIM_BITS-1:0] RST_VIEW_W    = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0] RST_VIEW_H    = DIM_BITS'(600);
  localparam logic [DIM_BITS-1:0] RST_CONTENT_W = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0] RST_CONTENT_H = DIM_BITS'(600);
  localparam logic [OFS_BITS-1:0] RST_OFS_X     = OFS_BITS'(0);
  localparam logic [OFS_BITS-1:0] RST_OFS_Y     = OFS_BITS'(150);

  localparam logic [OPC_BITS-1:0] OPC_CORNER_JUMP = OPC_BITS'(0);
  localparam logic [OPC_BITS-1:0] OPC_CORNER_PAN  = OPC_BITS'(1);
  localparam logic [OPC_BITS-1:0] OPC_CENTRE_JUMP = OPC_BITS'(2);
  localparam logic [OPC_BITS-1:0] OPC_CENTRE_PAN  = OPC_BITS'(3);
  localparam logic [OPC_BITS-1:0] OPC_TICK        = OPC_BITS'(4);

  localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_W    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_VIEW_H    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONTENT_W = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONTENT_H = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFS_X     = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFS_Y     = CFG_IDX_BITS'(5);

  typedef enum logic [2:0] {
    DP_NONE,
    DP_CLAMP,
    DP_APPLY,
    DP_ACCUM,
    DP_FINISH,
    DP_MUL,
    DP_DIV_GO,
    DP_UPDATE
  } dp_op_e;

  typedef struct packed {
    logic   in_ready;
    dp_op_e op;
    logic   axis_y;
    logic   out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                in_valid;
    logic [OPC_BITS-1:0] opcode;
    logic                pan_active;
    logic                pan_end;
    logic                div_done;
    logic                out_free;
  } dp_stat_t;

endpackage

// ===== src/vppc_if.sv =====
// Command, result and configuration channel interfaces.
interface vppc_cmd_if import vppc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OPC_BITS-1:0]         opcode;
  logic signed [SPOS_BITS-1:0] pos_x;
  logic signed [SPOS_BITS-1:0] pos_y;
  logic [TIME_BITS-1:0]        duration;
  logic [TIME_BITS-1:0]        delta_time;

  modport source (output valid, opcode, pos_x, pos_y, duration, delta_time, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, duration, delta_time, output ready);
endinterface

interface vppc_res_if import vppc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] view_x;
  logic [POS_BITS-1:0] view_y;
  logic                animating;

  modport source (output valid, view_x, view_y, animating, input ready);
  modport sink (input valid, view_x, view_y, animating, output ready);
endinterface

interface vppc_cfg_if import vppc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/viewport_pan_clamp_animator.sv =====
// Top level of the scrolling viewport controller with clamped targets and timed panning.
// Each command on cmd_i (corner or centre target, jump or pan, or a tick) returns exactly one
// transfer on res_o with the current corner in unsigned 12.8 pixels and the animating flag.
// One command is worked on at a time. A jump or pan start clamps both axes and applies the
// targets; an idle tick or unused opcode goes straight to the result; a tick that ends the
// pan snaps to the destination; and a tick that steps the pan runs a bit-serial divide once
// per axis on one shared divider. A finished result waits in an output register while the
// next command is already taken. Configuration writes on cfg_i are taken in any cycle and
// must only be issued while no command is outstanding.
module viewport_pan_clamp_animator import vppc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vppc_cmd_if.sink   cmd_i,
  vppc_res_if.source res_o,
  vppc_cfg_if.sink   cfg_i
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  vppc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (ctl)
  );

  vppc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .ctl_i  (ctl),
    .stat_o (stat)
  );

endmodule

// ===== src/vppc_div.sv =====
// Restoring divider that produces one quotient bit per cycle for the pan step.
module vppc_div import vppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_BITS-1:0] num_i,
  input  logic [TIME_BITS-1:0] den_i,
  output logic                 done_o,
  output logic [POS_BITS-1:0]  quot_o
);

  logic [TIME_BITS-1:0]    rem_q;
  logic [TIME_BITS-1:0]    den_q;
  logic [POS_BITS-1:0]     acc_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    done_q;
  logic [TIME_BITS:0]      trial;
  logic                    fits;

  assign trial = {rem_q, acc_q[POS_BITS-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DIV_CNT_BITS'(POS_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - DIV_CNT_BITS'(1);
      done_q <= (cnt_q == DIV_CNT_BITS'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // The quotient is known to fit in POS_BITS, so the upper part of the
  // dividend starts out as a partial remainder below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[PROD_BITS-1:POS_BITS];
      acc_q <= num_i[POS_BITS-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? TIME_BITS'(trial - {1'b0, den_q}) : trial[TIME_BITS-1:0];
      acc_q <= {acc_q[POS_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("Divider restarted while a division was running.");

endmodule

// ===== src/vppc_dp.sv =====
// Datapath: configuration registers, target clamping, pan state, step unit and result register.
module vppc_dp import vppc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vppc_cmd_if.sink   cmd_i,
  vppc_res_if.source res_o,
  vppc_cfg_if.sink   cfg_i,
  input  ctrl_cmd_t  ctl_i,
  output dp_stat_t   stat_o
);

  function automatic logic [POS_BITS-1:0] sat_pos(input logic signed [CALC_BITS-1:0] r);
    logic [POS_BITS-1:0] res;
    if (r < 0) begin
      res = '0;
    end else if (r > POS_MAX_C) begin
      res = '1;
    end else begin
      res = r[POS_BITS-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [CALC_BITS-1:0] fx_dim(input logic [DIM_BITS-1:0] d);
    return $signed({{(CALC_BITS-DIM_BITS-FRAC_BITS){1'b0}}, d, {FRAC_BITS{1'b0}}});
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_corner(
    input logic signed [SPOS_BITS-1:0] p,
    input logic [DIM_BITS-1:0]         view,
    input logic [DIM_BITS-1:0]         content
  );
    logic [DIM_BITS-1:0]         ev;
    logic signed [CALC_BITS-1:0] ps;
    logic signed [CALC_BITS-1:0] v;
    logic signed [CALC_BITS-1:0] c;
    logic signed [CALC_BITS-1:0] r;
    ev = (view > content) ? view : content;
    ps = CALC_BITS'(p);
    v  = fx_dim(ev);
    c  = fx_dim(content);
    if (ps < 0) begin
      r = '0;
    end else if (ps + c > v) begin
      r = v - c;
    end else begin
      r = ps;
    end
    return sat_pos(r);
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_centre(
    input logic signed [SPOS_BITS-1:0] p,
    input logic [DIM_BITS-1:0]         view,
    input logic [DIM_BITS-1:0]         content,
    input logic [OFS_BITS-1:0]         ofs
  );
    logic [DIM_BITS-1:0]         ev;
    logic signed [HALF_BITS-1:0] diff;
    logic signed [HALF_BITS-1:0] h;
    logic signed [CALC_BITS-1:0] ps;
    logic signed [CALC_BITS-1:0] v;
    logic signed [CALC_BITS-1:0] fh;
    logic signed [CALC_BITS-1:0] q;
    ev   = (view > content) ? view : content;
    diff = $signed({1'b0, content}) - $signed({2'b0, ofs});
    // Halve with truncation toward zero.
    h    = (diff + $signed({{(HALF_BITS-1){1'b0}}, diff[HALF_BITS-1]})) >>> 1;
    fh   = CALC_BITS'(h) <<< FRAC_BITS;
    ps   = CALC_BITS'(p);
    v    = fx_dim(ev);
    if (ps + fh > v) begin
      q = v - fh;
    end else if (ps - fh < 0) begin
      q = fh;
    end else begin
      q = ps;
    end
    return sat_pos(q - fh);
  endfunction

  logic [DIM_BITS-1:0] view_w_q, view_h_q, content_w_q, content_h_q;
  logic [OFS_BITS-1:0] ofs_x_q, ofs_y_q;

  logic [OPC_BITS-1:0]         opc_q;
  logic signed [SPOS_BITS-1:0] px_q, py_q;
  logic [TIME_BITS-1:0]        dur_q, dt_q;

  logic [POS_BITS-1:0]         tx_q, ty_q;
  logic [POS_BITS-1:0]         cur_x_q, cur_y_q, dest_x_q, dest_y_q;
  logic signed [SPOS_BITS-1:0] dist_x_q, dist_y_q;
  logic [ELAP_BITS-1:0]        elapsed_q;
  logic [TIME_BITS-1:0]        pan_time_q;
  logic                        pan_active_q;
  logic [PROD_BITS-1:0]        prod_q;

  logic                res_valid_q;
  logic [POS_BITS-1:0] view_x_q, view_y_q;
  logic                animating_q;

  logic                        accept;
  logic                        is_corner;
  logic                        is_jump;
  logic                        pan_end;
  logic signed [SPOS_BITS-1:0] sel_p;
  logic [DIM_BITS-1:0]         sel_view, sel_content;
  logic [OFS_BITS-1:0]         sel_ofs;
  logic [POS_BITS-1:0]         target;
  logic [POS_BITS-1:0]         u_cur, u_dest, u_mag;
  logic signed [SPOS_BITS-1:0] u_dist;
  logic                        u_neg;
  logic signed [CALC_BITS-1:0] q_s, step_s, cur_s, dest_s, nx_s;
  logic [POS_BITS-1:0]         u_next;
  logic                        div_done;
  logic [POS_BITS-1:0]         quot;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = ctl_i.in_ready;
  assign accept      = cmd_i.valid & cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w_q    <= RST_VIEW_W;
      view_h_q    <= RST_VIEW_H;
      content_w_q <= RST_CONTENT_W;
      content_h_q <= RST_CONTENT_H;
      ofs_x_q     <= RST_OFS_X;
      ofs_y_q     <= RST_OFS_Y;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_VIEW_W:    view_w_q    <= cfg_i.data;
        CFG_VIEW_H:    view_h_q    <= cfg_i.data;
        CFG_CONTENT_W: content_w_q <= cfg_i.data;
        CFG_CONTENT_H: content_h_q <= cfg_i.data;
        CFG_OFS_X:     ofs_x_q     <= cfg_i.data[OFS_BITS-1:0];
        CFG_OFS_Y:     ofs_y_q     <= cfg_i.data[OFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opc_q <= cmd_i.opcode;
      px_q  <= cmd_i.pos_x;
      py_q  <= cmd_i.pos_y;
      dur_q <= cmd_i.duration;
      dt_q  <= cmd_i.delta_time;
    end
  end

  assign is_corner = (opc_q == OPC_CORNER_JUMP) || (opc_q == OPC_CORNER_PAN);
  assign is_jump   = (opc_q == OPC_CORNER_JUMP) || (opc_q == OPC_CENTRE_JUMP);

  assign sel_p       = ctl_i.axis_y ? py_q : px_q;
  assign sel_view    = ctl_i.axis_y ? view_h_q : view_w_q;
  assign sel_content = ctl_i.axis_y ? content_h_q : content_w_q;
  assign sel_ofs     = ctl_i.axis_y ? ofs_y_q : ofs_x_q;
  assign target      = is_corner ? clamp_corner(sel_p, sel_view, sel_content)
                                 : clamp_centre(sel_p, sel_view, sel_content, sel_ofs);

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_CLAMP) begin
      if (ctl_i.axis_y) begin
        ty_q <= target;
      end else begin
        tx_q <= target;
      end
    end
  end

  assign u_cur  = ctl_i.axis_y ? cur_y_q : cur_x_q;
  assign u_dest = ctl_i.axis_y ? dest_y_q : dest_x_q;
  assign u_dist = ctl_i.axis_y ? dist_y_q : dist_x_q;
  assign u_neg  = u_dist[SPOS_BITS-1];
  assign u_mag  = POS_BITS'(u_neg ? -u_dist : u_dist);

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == DP_MUL) begin
      prod_q <= u_mag * dt_q;
    end
  end

  vppc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.op == DP_DIV_GO),
    .num_i   (prod_q),
    .den_i   (pan_time_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Step toward the target and snap to it once it is reached or passed.
  always_comb begin
    q_s    = $signed({{(CALC_BITS-POS_BITS){1'b0}}, quot});
    step_s = u_neg ? -q_s : q_s;
    cur_s  = $signed({{(CALC_BITS-POS_BITS){1'b0}}, u_cur});
    dest_s = $signed({{(CALC_BITS-POS_BITS){1'b0}}, u_dest});
    nx_s   = cur_s + step_s;
    if ((u_dist > 0 && nx_s >= dest_s) || (u_neg && nx_s < dest_s)) begin
      u_next = u_dest;
    end else begin
      u_next = sat_pos(nx_s);
    end
  end

  assign pan_end = (pan_time_q == '0) || (elapsed_q > {1'b0, pan_time_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      dest_x_q     <= '0;
      dest_y_q     <= '0;
      dist_x_q     <= '0;
      dist_y_q     <= '0;
      elapsed_q    <= '0;
      pan_time_q   <= '0;
      pan_active_q <= 1'b0;
    end else begin
      unique case (ctl_i.op)
        DP_APPLY: begin
          if (is_jump) begin
            cur_x_q <= tx_q;
            cur_y_q <= ty_q;
          end else begin
            dest_x_q     <= tx_q;
            dest_y_q     <= ty_q;
            dist_x_q     <= $signed({1'b0, tx_q}) - $signed({1'b0, cur_x_q});
            dist_y_q     <= $signed({1'b0, ty_q}) - $signed({1'b0, cur_y_q});
            elapsed_q    <= '0;
            pan_time_q   <= dur_q;
            pan_active_q <= 1'b1;
          end
        end
        DP_ACCUM: begin
          elapsed_q <= elapsed_q + {1'b0, dt_q};
        end
        DP_FINISH: begin
          cur_x_q      <= dest_x_q;
          cur_y_q      <= dest_y_q;
          pan_active_q <= 1'b0;
        end
        DP_UPDATE: begin
          if (ctl_i.axis_y) begin
            cur_y_q <= u_next;
          end else begin
            cur_x_q <= u_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      view_x_q    <= cur_x_q;
      view_y_q    <= cur_y_q;
      animating_q <= pan_active_q;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.view_x    = view_x_q;
  assign res_o.view_y    = view_y_q;
  assign res_o.animating = animating_q;

  assign stat_o.in_valid   = cmd_i.valid;
  assign stat_o.opcode     = opc_q;
  assign stat_o.pan_active = pan_active_q;
  assign stat_o.pan_end    = pan_end;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !res_valid_q || res_o.ready;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> !res_valid_q || res_o.ready)
    else $error("Result register loaded while a result was still pending.");

  a_step_in_pan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == DP_MUL |-> pan_active_q && !pan_end)
    else $error("Pan step started outside a running pan.");

  a_pan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pan_active_q) |-> elapsed_q == '0)
    else $error("Pan started with nonzero elapsed time.");

endmodule

// ===== src/vppc_ctrl.sv =====
// Controller state machine that sequences the datapath for each command.
module vppc_ctrl import vppc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLAMP_X,
    ST_CLAMP_Y,
    ST_APPLY,
    ST_ACCUM,
    ST_CHECK,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;

  always_comb begin
    state_d        = state_q;
    axis_d         = axis_q;
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = DP_NONE;
    cmd_o.axis_y   = axis_q;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.opcode) inside
          OPC_CORNER_JUMP, OPC_CORNER_PAN, OPC_CENTRE_JUMP, OPC_CENTRE_PAN: begin
            state_d = ST_CLAMP_X;
          end
          OPC_TICK: begin
            state_d = stat_i.pan_active ? ST_ACCUM : ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_CLAMP_X: begin
        cmd_o.op     = DP_CLAMP;
        cmd_o.axis_y = 1'b0;
        state_d      = ST_CLAMP_Y;
      end
      ST_CLAMP_Y: begin
        cmd_o.op     = DP_CLAMP;
        cmd_o.axis_y = 1'b1;
        state_d      = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.op = DP_APPLY;
        state_d  = ST_DONE;
      end
      ST_ACCUM: begin
        cmd_o.op = DP_ACCUM;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.pan_end) begin
          cmd_o.op = DP_FINISH;
          state_d  = ST_DONE;
        end else begin
          axis_d  = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.op = DP_DIV_GO;
        state_d  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.op = DP_UPDATE;
        if (axis_q) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

// ===== test/viewport_pan_clamp_animator_tb.sv =====
// Self-checking testbench for the viewport pan controller: directed table, then random phases.
module viewport_pan_clamp_animator_tb import vppc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPC_BITS-1:0] OPC_SPARE_5 = OPC_BITS'(5);
  localparam logic [OPC_BITS-1:0] OPC_SPARE_6 = OPC_BITS'(6);
  localparam logic [OPC_BITS-1:0] OPC_SPARE_7 = OPC_BITS'(7);
  localparam logic signed [SPOS_BITS-1:0] POS_HI = {1'b0, {POS_BITS{1'b1}}};
  localparam logic signed [SPOS_BITS-1:0] POS_LO = {1'b1, {POS_BITS{1'b0}}};
  localparam logic [TIME_BITS-1:0] TIME_HI = {TIME_BITS{1'b1}};
  localparam longint ONE_PX = longint'(1) << FRAC_BITS;
  localparam longint CORNER_MAX = (longint'(1) << POS_BITS) - 1;

  typedef struct packed {
    logic [POS_BITS-1:0] view_x;
    logic [POS_BITS-1:0] view_y;
    logic                animating;
  } view_state_t;

  typedef struct packed {
    logic [OPC_BITS-1:0]         opcode;
    logic signed [SPOS_BITS-1:0] pos_x;
    logic signed [SPOS_BITS-1:0] pos_y;
    logic [TIME_BITS-1:0]        duration;
    logic [TIME_BITS-1:0]        delta_time;
  } pan_cmd_t;

  typedef struct {
    bit                      is_cfg;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    int                      reg_val;
    pan_cmd_t                cmd;
    bit                      has_view;
    view_state_t             view;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vppc_cmd_if cmd_bus ();
  vppc_res_if res_bus ();
  vppc_cfg_if cfg_bus ();

  viewport_pan_clamp_animator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always #1 clk_i = ~clk_i;

  longint reg_view_w = RST_VIEW_W;
  longint reg_view_h = RST_VIEW_H;
  longint reg_content_w = RST_CONTENT_W;
  longint reg_content_h = RST_CONTENT_H;
  longint reg_ofs_x = RST_OFS_X;
  longint reg_ofs_y = RST_OFS_Y;

  longint corner_x = 0, corner_y = 0, goal_x = 0, goal_y = 0, span_x = 0, span_y = 0;
  longint time_run = 0, time_total = 0;
  bit     panning = 1'b0;

  view_state_t pending_views[$];
  script_row_t script[$];
  int          errors = 0;
  int          cmds_sent = 0;
  int          sender_gap = 0;
  int          receiver_stall = 0;
  int          hold_total = 0;
  int          hold_count = 0;
  view_state_t want_view;

  function automatic longint sat_corner(longint v);
    if (v < 0) return 0;
    if (v > CORNER_MAX) return CORNER_MAX;
    return v;
  endfunction

  function automatic longint clamp_corner(longint p, longint view, longint content);
    longint span_view;
    longint span_content;
    span_view = ((view > content) ? view : content) * ONE_PX;
    span_content = content * ONE_PX;
    if (p < 0) p = 0;
    else if (p + span_content > span_view) p = span_view - span_content;
    return sat_corner(p);
  endfunction

  function automatic longint clamp_centre(longint p, longint view, longint content,
                                          longint offset);
    longint half;
    longint span_view;
    half = (content - offset) / 2;
    span_view = (view > content) ? view : content;
    if (p + half * ONE_PX > span_view * ONE_PX) p = (span_view - half) * ONE_PX;
    else if (p - half * ONE_PX < 0) p = half * ONE_PX;
    return sat_corner(p - half * ONE_PX);
  endfunction

  function automatic longint step_axis(longint pos, longint span, longint goal, longint dt);
    longint moved;
    moved = pos + span * dt / time_total;
    if ((span > 0 && moved >= goal) || (span < 0 && moved < goal)) moved = goal;
    return sat_corner(moved);
  endfunction

  function automatic view_state_t predict_view(pan_cmd_t c);
    longint      px;
    longint      py;
    longint      tx;
    longint      ty;
    longint      dt;
    view_state_t v;
    px = longint'(c.pos_x);
    py = longint'(c.pos_y);
    dt = longint'(c.delta_time);
    tx = 0;
    ty = 0;
    if (c.opcode == OPC_CORNER_JUMP || c.opcode == OPC_CORNER_PAN) begin
      tx = clamp_corner(px, reg_view_w, reg_content_w);
      ty = clamp_corner(py, reg_view_h, reg_content_h);
    end else if (c.opcode == OPC_CENTRE_JUMP || c.opcode == OPC_CENTRE_PAN) begin
      tx = clamp_centre(px, reg_view_w, reg_content_w, reg_ofs_x);
      ty = clamp_centre(py, reg_view_h, reg_content_h, reg_ofs_y);
    end
    if (c.opcode == OPC_CORNER_JUMP || c.opcode == OPC_CENTRE_JUMP) begin
      corner_x = tx;
      corner_y = ty;
    end else if (c.opcode == OPC_CORNER_PAN || c.opcode == OPC_CENTRE_PAN) begin
      goal_x = tx;
      goal_y = ty;
      span_x = goal_x - corner_x;
      span_y = goal_y - corner_y;
      panning = 1'b1;
      time_run = 0;
      time_total = longint'(c.duration);
    end else if (c.opcode == OPC_TICK && panning) begin
      time_run += dt;
      if (time_total == 0 || time_run > time_total) begin
        panning = 1'b0;
        corner_x = goal_x;
        corner_y = goal_y;
      end else begin
        corner_x = step_axis(corner_x, span_x, goal_x, dt);
        corner_y = step_axis(corner_y, span_y, goal_y, dt);
      end
    end
    v.view_x = POS_BITS'(corner_x);
    v.view_y = POS_BITS'(corner_y);
    v.animating = panning;
    return v;
  endfunction

  function automatic pan_cmd_t make_cmd(logic [OPC_BITS-1:0] op, logic signed [SPOS_BITS-1:0] x,
                                        logic signed [SPOS_BITS-1:0] y,
                                        logic [TIME_BITS-1:0] dur, logic [TIME_BITS-1:0] dt);
    pan_cmd_t c;
    c.opcode = op;
    c.pos_x = x;
    c.pos_y = y;
    c.duration = dur;
    c.delta_time = dt;
    return c;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_BITS-1:0] idx, int val);
    script_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    script.insert(script.size(), r);
  endfunction

  function automatic void add_row(pan_cmd_t c, bit has_view, int vx, int vy, bit anim);
    script_row_t r;
    r = '{default: '0};
    r.cmd = c;
    r.has_view = has_view;
    r.view.view_x = POS_BITS'(vx);
    r.view.view_y = POS_BITS'(vy);
    r.view.animating = anim;
    script.insert(script.size(), r);
  endfunction

  function automatic logic signed [SPOS_BITS-1:0] rand_pos();
    case ($urandom_range(3))
      0:       return SPOS_BITS'($urandom);
      3:       return -SPOS_BITS'($urandom_range(0, 5000));
      default: return SPOS_BITS'($urandom_range(0, int'(POS_HI)));
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_duration();
    case ($urandom_range(9))
      0:          return '0;
      1:          return TIME_BITS'($urandom);
      2, 3, 4:    return TIME_BITS'($urandom_range(1, 64));
      default:    return TIME_BITS'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_dt(logic [TIME_BITS-1:0] dur);
    case ($urandom_range(7))
      0:       return TIME_BITS'($urandom);
      1:       return '0;
      default: return TIME_BITS'($urandom_range(0, int'(dur) / 3 + 1));
    endcase
  endfunction

  task automatic send_cmd(pan_cmd_t c, bit has_view, view_state_t typed_view);
    view_state_t v;
    cfg_bus.valid <= 1'b0;
    if (sender_gap > 0 && $urandom_range(99) < sender_gap) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.opcode     <= c.opcode;
    cmd_bus.pos_x      <= c.pos_x;
    cmd_bus.pos_y      <= c.pos_y;
    cmd_bus.duration   <= c.duration;
    cmd_bus.delta_time <= c.delta_time;
    do @(posedge clk_i); while (!cmd_bus.ready);
    v = predict_view(c);
    pending_views.insert(pending_views.size(), has_view ? typed_view : v);
    cmds_sent++;
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_BITS'(val);
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_VIEW_W:    reg_view_w = val & 'h1FFF;
      CFG_VIEW_H:    reg_view_h = val & 'h1FFF;
      CFG_CONTENT_W: reg_content_w = val & 'h1FFF;
      CFG_CONTENT_H: reg_content_h = val & 'h1FFF;
      CFG_OFS_X:     reg_ofs_x = val & 'hFFF;
      CFG_OFS_Y:     reg_ofs_y = val & 'hFFF;
      default: ;
    endcase
  endtask

  task automatic run_phase(int vw, int vh, int cw, int ch, int ox, int oy,
                           int gap, int stall, int hold, int n_items);
    pan_cmd_t             c;
    logic [TIME_BITS-1:0] dur;
    int                   target;
    write_reg(CFG_VIEW_W, vw);
    write_reg(CFG_VIEW_H, vh);
    write_reg(CFG_CONTENT_W, cw);
    write_reg(CFG_CONTENT_H, ch);
    write_reg(CFG_OFS_X, ox);
    write_reg(CFG_OFS_Y, oy);
    sender_gap = gap;
    receiver_stall = stall;
    hold_total += hold;
    target = cmds_sent + n_items;
    while (cmds_sent < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          dur = rand_duration();
          c = make_cmd($urandom_range(1) ? OPC_CORNER_PAN : OPC_CENTRE_PAN,
                       rand_pos(), rand_pos(), dur, TIME_BITS'($urandom));
          send_cmd(c, 1'b0, '0);
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(9) == 0) begin
              c = make_cmd($urandom_range(1) ? OPC_CORNER_JUMP : OPC_CENTRE_JUMP,
                           rand_pos(), rand_pos(), TIME_BITS'($urandom), TIME_BITS'($urandom));
            end else begin
              c = make_cmd(OPC_TICK, SPOS_BITS'($urandom), SPOS_BITS'($urandom),
                           TIME_BITS'($urandom), rand_dt(dur));
            end
            send_cmd(c, 1'b0, '0);
          end
        end
        6, 7: begin
          c = make_cmd($urandom_range(1) ? OPC_CORNER_JUMP : OPC_CENTRE_JUMP,
                       rand_pos(), rand_pos(), TIME_BITS'($urandom), TIME_BITS'($urandom));
          send_cmd(c, 1'b0, '0);
        end
        8: begin
          c = make_cmd(OPC_TICK, SPOS_BITS'($urandom), SPOS_BITS'($urandom),
                       TIME_BITS'($urandom), TIME_BITS'($urandom));
          send_cmd(c, 1'b0, '0);
        end
        default: begin
          c = make_cmd(OPC_BITS'($urandom_range(5, 7)), SPOS_BITS'($urandom),
                       SPOS_BITS'($urandom), TIME_BITS'($urandom), TIME_BITS'($urandom));
          send_cmd(c, 1'b0, '0);
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_count < hold_total) begin
      res_bus.ready <= 1'b0;
      hold_count++;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_views.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, got x=%0d y=%0d anim=%0b",
                 $time, res_bus.view_x, res_bus.view_y, res_bus.animating);
      end else begin
        want_view = pending_views.pop_front();
        if (res_bus.view_x !== want_view.view_x || res_bus.view_y !== want_view.view_y ||
            res_bus.animating !== want_view.animating) begin
          errors++;
          $display("%0t ns: expected x=%0d y=%0d anim=%0b, got x=%0d y=%0d anim=%0b",
                   $time, want_view.view_x, want_view.view_y, want_view.animating,
                   res_bus.view_x, res_bus.view_y, res_bus.animating);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("viewport_pan_clamp_animator_tb: FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.opcode = '0;
    cmd_bus.pos_x = '0;
    cmd_bus.pos_y = '0;
    cmd_bus.duration = '0;
    cmd_bus.delta_time = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;

    // Rows with typed values are read straight off the reset settings or the clamp limits.
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 100), 1'b1, 0, 0, 1'b0);
    add_row(make_cmd(OPC_SPARE_5, POS_HI, POS_LO, TIME_HI, TIME_HI), 1'b1, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CORNER_JUMP, POS_HI, POS_HI, 0, 0), 1'b1, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CORNER_JUMP, POS_LO, POS_LO, 0, 0), 1'b1, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CENTRE_JUMP, 0, 0, 0, 0), 1'b1, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CENTRE_JUMP, POS_HI, POS_HI, 0, 0), 1'b1, 0, 38400, 1'b0);
    add_cfg(CFG_VIEW_W, 4096);
    add_cfg(CFG_VIEW_H, 4096);
    add_cfg(CFG_CONTENT_W, 1);
    add_cfg(CFG_CONTENT_H, 1);
    add_cfg(CFG_OFS_X, 0);
    add_cfg(CFG_OFS_Y, 4095);
    add_row(make_cmd(OPC_CORNER_JUMP, POS_HI, POS_HI, 0, 0), 1'b1, 1048320, 1048320, 1'b0);
    add_row(make_cmd(OPC_CORNER_PAN, 0, 0, 0, 0), 1'b1, 1048320, 1048320, 1'b1);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 0), 1'b1, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CORNER_PAN, 25600, 51200, TIME_HI, 0), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, TIME_HI), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 1), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CENTRE_PAN, 524288, POS_LO, 10, 0), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 3), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 3), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 20), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CORNER_PAN, 1000, 2000, 100, 0), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 10), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CENTRE_JUMP, 300000, 300000, 0, 0), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 50), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_TICK, 0, 0, 0, 50), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_SPARE_6, POS_LO, POS_HI, 0, 0), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_SPARE_7, POS_HI, POS_LO, 0, 0), 1'b0, 0, 0, 1'b0);
    add_row(make_cmd(OPC_CENTRE_JUMP, POS_LO, POS_HI, 0, 0), 1'b0, 0, 0, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].reg_idx, script[i].reg_val);
      else send_cmd(script[i].cmd, script[i].has_view, script[i].view);
    end

    run_phase(4096, 4096, 1, 1, 0, 0, 0, 0, 0, 100);
    run_phase(1, 1, 4096, 4096, 4095, 4095, 51, 0, 0, 100);
    run_phase(1024, 768, 640, 480, 100, 37, 0, 51, 0, 100);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096),
              $urandom_range(1, 4096), $urandom_range(0, 4095), $urandom_range(0, 4095),
              30, 30, 0, 100);
    // The receiver holds off long enough for the output register and the input to back up.
    run_phase(4096, 1, 1, 4096, 4095, 0, 0, 0, 400, 100);

    wait_idle();
    repeat (64) @(posedge clk_i);
    if (errors == 0) $display("viewport_pan_clamp_animator_tb: PASS");
    else $display("viewport_pan_clamp_animator_tb: FAIL");
    $finish;
  end

endmodule
